[sv/bslfo_pkg.sv]
// Shared types, constants and the quarter-wave cosine table for the beat-synced LFO.
package bslfo_pkg;

  // Input and output formats.
  localparam int PosW        = 32;
  localparam int PosFracBits = 16;
  localparam int PhaseW      = 16;
  localparam int ShapeW      = PhaseW + 1;
  localparam int ValueW      = 16;
  localparam int CfgIndexW   = 3;
  localparam int CfgDataW    = 16;
  localparam int PeriodSelW  = 4;

  localparam logic [ShapeW-1:0] ShapeOne = ShapeW'(1 << PhaseW);

  // Six-beat period: the position splits at 2^(PosFracBits+1), which is 1/3 of the period.
  localparam int LowW  = PosFracBits + 1;
  localparam int HighW = PosW - LowW;

  // Reciprocal constants for exact division by three (error term one over 2^shift).
  localparam int Mod3Shift = (HighW % 2 == 1) ? HighW : HighW + 1;
  localparam longint unsigned Mod3Mult = ((64'd1 << Mod3Shift) + 64'd1) / 3;
  localparam int Mod3MultW = $clog2(Mod3Mult + 1);

  localparam int SixW      = PhaseW + 2;
  localparam int Div3Shift = (SixW % 2 == 1) ? SixW : SixW + 1;
  localparam longint unsigned Div3Mult = ((64'd1 << Div3Shift) + 64'd1) / 3;
  localparam int Div3MultW = $clog2(Div3Mult + 1);

  // Shift amount of a power-of-two period in position units.
  localparam int ShiftW = $clog2(PosFracBits + 6);

  // Period selector codes that need their own handling.
  localparam logic [PeriodSelW-1:0] PeriodSixBeats = PeriodSelW'(6);

  typedef enum logic [1:0] {
    WaveSine     = 2'd0,
    WaveTriangle = 2'd1,
    WaveSaw      = 2'd2,
    WaveSquare   = 2'd3
  } waveform_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgPeriodSelect = 3'd0,
    CfgWaveform     = 3'd1,
    CfgOutMin       = 3'd2,
    CfgOutMax       = 3'd3,
    CfgInvert       = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [PeriodSelW-1:0] period_select;
    waveform_e             waveform;
    logic [ValueW-1:0]     out_min;
    logic [ValueW-1:0]     span;
    logic                  invert;
  } cfg_t;

  // Quarter-wave cosine table, Q1.16, built at elaboration from a Q30 Taylor series.
  localparam int SineTableDepth = 256;
  localparam int SineIdxW       = $clog2(SineTableDepth + 1);
  localparam int TaylorTerms    = 10;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  typedef logic [ShapeW-1:0] cos_tab_t [SineTableDepth+1];

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint sum;
    for (int k = 0; k <= SineTableDepth; k++) begin
      x    = (HalfPiQ30 * 64'(k)) / SineTableDepth;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = $signed(term);
      for (int n = 1; n <= TaylorTerms; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum <= 0) begin
        tab[k] = '0;
      end else begin
        v = ($unsigned(sum) + (64'd1 << 13)) >> 14;
        tab[k] = (v > 64'(ShapeOne)) ? ShapeOne : ShapeW'(v);
      end
    end
    return tab;
  endfunction

  localparam cos_tab_t CosTab = build_cos_tab();

endpackage

[sv/bslfo_phase.sv]
// Three-stage phase extraction: position modulo the period, scaled to a Q0.16 fraction.
module bslfo_phase (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic [bslfo_pkg::PosW-1:0]      beat_position_i,
  input  bslfo_pkg::cfg_t                 cfg_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic [bslfo_pkg::PhaseW-1:0]    phase_o
);
  import bslfo_pkg::*;

  localparam int Mod3ProdW = HighW + Mod3MultW;
  localparam int Div3ProdW = SixW + Div3MultW;

  logic s1_v_q, s2_v_q, s3_v_q;
  logic stall1, stall2, stall3;

  // Stage 1: period decode, power-of-two phase, reciprocal product for the six-beat case.
  logic [ShiftW-1:0]    log2_eighths;
  logic                 six;
  logic [ShiftW-1:0]    shift;
  logic [PosW-1:0]      mask;
  logic [PosW+PhaseW-1:0] wide;
  logic [HighW-1:0]     hi;
  logic [Mod3ProdW-1:0] m3_prod;

  logic [HighW-1:0]     s1_hi_q;
  logic [LowW-1:0]      s1_lo_q;
  logic [Mod3ProdW-1:0] s1_prod_q;
  logic [PhaseW-1:0]    s1_php2_q;
  logic                 s1_six_q;

  always_comb begin
    six = 1'b0;
    unique case (cfg_i.period_select)
      4'd0:           log2_eighths = ShiftW'(0);
      4'd1:           log2_eighths = ShiftW'(1);
      4'd2:           log2_eighths = ShiftW'(2);
      4'd3:           log2_eighths = ShiftW'(3);
      4'd4:           log2_eighths = ShiftW'(4);
      4'd5:           log2_eighths = ShiftW'(5);
      PeriodSixBeats: begin
        log2_eighths = ShiftW'(5);
        six          = 1'b1;
      end
      4'd7:           log2_eighths = ShiftW'(6);
      4'd8:           log2_eighths = ShiftW'(7);
      default:        log2_eighths = ShiftW'(8);
    endcase
  end

  assign shift   = ShiftW'(PosFracBits - 3) + log2_eighths;
  assign mask    = ~({PosW{1'b1}} << shift);
  assign wide    = {beat_position_i & mask, {PhaseW{1'b0}}} >> shift;
  assign hi      = beat_position_i[PosW-1:LowW];
  assign m3_prod = Mod3ProdW'(hi) * Mod3ProdW'(Mod3Mult);

  // Stage 2: remainder of the upper part modulo three, then divide the reduced value by three.
  logic [HighW-1:0]         quo;
  logic [HighW-1:0]         rem_full;
  logic [1:0]               rem;
  logic [LowW+1:0]          r;
  logic [LowW+1+PhaseW:0]   r_wide;
  logic [SixW-1:0]          y;
  logic [Div3ProdW-1:0]     d3_prod;

  logic [Div3ProdW-1:0]     s2_prod_q;
  logic [PhaseW-1:0]        s2_php2_q;
  logic                     s2_six_q;

  assign quo      = HighW'(s1_prod_q >> Mod3Shift);
  assign rem_full = s1_hi_q - (quo + (quo << 1));
  assign rem      = rem_full[1:0];
  assign r        = {rem, s1_lo_q};
  assign r_wide   = {r, {PhaseW{1'b0}}} >> LowW;
  assign y        = r_wide[SixW-1:0];
  assign d3_prod  = Div3ProdW'(y) * Div3ProdW'(Div3Mult);

  // Stage 3: pick the phase of the active period kind.
  logic [PhaseW-1:0] ph;
  logic [PhaseW-1:0] s3_ph_q;

  assign ph = s2_six_q ? s2_prod_q[Div3Shift +: PhaseW] : s2_php2_q;

  // Handshake: a stage holds only when it is full and the next one holds.
  assign stall3  = s3_v_q && stall_i;
  assign stall2  = s2_v_q && stall3;
  assign stall1  = s1_v_q && stall2;
  assign stall_o = stall1;
  assign valid_o = s3_v_q;
  assign phase_o = s3_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (!stall1) s1_v_q <= valid_i;
      if (!stall2) s2_v_q <= s1_v_q;
      if (!stall3) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall1 && valid_i) begin
      s1_hi_q   <= hi;
      s1_lo_q   <= beat_position_i[LowW-1:0];
      s1_prod_q <= m3_prod;
      s1_php2_q <= wide[PhaseW-1:0];
      s1_six_q  <= six;
    end
    if (!stall2 && s1_v_q) begin
      s2_prod_q <= d3_prod;
      s2_php2_q <= s1_php2_q;
      s2_six_q  <= s1_six_q;
    end
    if (!stall3 && s2_v_q) begin
      s3_ph_q <= ph;
    end
  end

  a_mod3_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (rem_full < HighW'(3)))
    else $error("six-beat remainder out of range");

  a_enter_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> s1_v_q)
    else $error("accepted transfer did not enter the first stage");

endmodule

[sv/bslfo_shape.sv]
// Two-stage waveform shaper: cosine table read, then selection of the waveform shape.
module bslfo_shape (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [bslfo_pkg::PhaseW-1:0]  phase_i,
  input  bslfo_pkg::cfg_t               cfg_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [bslfo_pkg::ShapeW-1:0]  shape_o,
  output logic [bslfo_pkg::PhaseW-1:0]  phase_o
);
  import bslfo_pkg::*;

  localparam int QuarterW = PhaseW - 2;
  localparam int IdxProdW = QuarterW + SineIdxW;

  logic s4_v_q, s5_v_q;
  logic stall4, stall5;

  // Stage 4: table index from the position inside the quadrant, mirrored in odd quadrants.
  logic [IdxProdW-1:0] idx_prod;
  logic [SineIdxW-1:0] idx_i;
  logic [SineIdxW-1:0] idx_j;
  logic [SineIdxW-1:0] idx;

  logic [ShapeW-1:0]   s4_cos_q;
  logic [PhaseW-1:0]   s4_ph_q;

  assign idx_prod = IdxProdW'(phase_i[QuarterW-1:0]) * IdxProdW'(SineTableDepth);
  assign idx_i    = SineIdxW'(idx_prod >> QuarterW);
  assign idx_j    = SineIdxW'(SineTableDepth) - idx_i;
  assign idx      = phase_i[QuarterW] ? idx_j : idx_i;

  // Stage 5: raised cosine, triangle, sawtooth or square.
  logic [ShapeW:0]   sine_sum;
  logic [ShapeW:0]   tri_down;
  logic [ShapeW-1:0] shape;

  logic [ShapeW-1:0] s5_shape_q;
  logic [PhaseW-1:0] s5_ph_q;

  always_comb begin
    if (s4_ph_q[PhaseW-1] ^ s4_ph_q[PhaseW-2]) begin
      sine_sum = {1'b0, ShapeOne} + {1'b0, s4_cos_q};
    end else begin
      sine_sum = {1'b0, ShapeOne} - {1'b0, s4_cos_q};
    end
    tri_down = ({1'b0, ShapeOne} - (ShapeW + 1)'(s4_ph_q)) << 1;
    case (cfg_i.waveform)
      WaveSine:     shape = sine_sum[ShapeW:1];
      WaveTriangle: shape = s4_ph_q[PhaseW-1] ? tri_down[ShapeW-1:0] : {s4_ph_q, 1'b0};
      WaveSaw:      shape = ShapeW'(s4_ph_q);
      WaveSquare:   shape = s4_ph_q[PhaseW-1] ? '0 : ShapeOne;
      default:      shape = '0;
    endcase
  end

  assign stall5  = s5_v_q && stall_i;
  assign stall4  = s4_v_q && stall5;
  assign stall_o = stall4;
  assign valid_o = s5_v_q;
  assign shape_o = s5_shape_q;
  assign phase_o = s5_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (!stall4) s4_v_q <= valid_i;
      if (!stall5) s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall4 && valid_i) begin
      s4_cos_q <= CosTab[idx];
      s4_ph_q  <= phase_i;
    end
    if (!stall5 && s4_v_q) begin
      s5_shape_q <= shape;
      s5_ph_q    <= s4_ph_q;
    end
  end

  a_shape_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_v_q |-> (s5_shape_q <= ShapeOne))
    else $error("waveform shape exceeds full scale");

endmodule

[sv/bslfo_scale.sv]
// Two-stage output scaler: shape times span, then offset, inversion and saturation.
module bslfo_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [bslfo_pkg::ShapeW-1:0]  shape_i,
  input  logic [bslfo_pkg::PhaseW-1:0]  phase_i,
  input  bslfo_pkg::cfg_t               cfg_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [bslfo_pkg::ValueW-1:0]  lfo_value_o,
  output logic [bslfo_pkg::PhaseW-1:0]  phase_o
);
  import bslfo_pkg::*;

  localparam int ProdW = ShapeW + ValueW;

  logic s6_v_q, s7_v_q;
  logic stall6, stall7;

  // Stage 6: scale the shape by the span.
  logic [ProdW-1:0]  prod;
  logic [ProdW-1:0]  s6_prod_q;
  logic [PhaseW-1:0] s6_ph_q;

  assign prod = ProdW'(shape_i) * ProdW'(cfg_i.span);

  // Stage 7: add the lower end, optionally invert, saturate to the output width.
  logic [ShapeW-1:0] val;
  logic [ShapeW-1:0] inv;
  logic [ValueW-1:0] sat;

  logic [ValueW-1:0] s7_val_q;
  logic [PhaseW-1:0] s7_ph_q;

  assign val = ShapeW'(cfg_i.out_min) + ShapeW'(ValueW'(s6_prod_q >> PhaseW));
  assign inv = cfg_i.invert ? (ShapeOne - val) : val;
  assign sat = inv[ShapeW-1] ? {ValueW{1'b1}} : inv[ValueW-1:0];

  assign stall7      = s7_v_q && stall_i;
  assign stall6      = s6_v_q && stall7;
  assign stall_o     = stall6;
  assign valid_o     = s7_v_q;
  assign lfo_value_o = s7_val_q;
  assign phase_o     = s7_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else begin
      if (!stall6) s6_v_q <= valid_i;
      if (!stall7) s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall6 && valid_i) begin
      s6_prod_q <= prod;
      s6_ph_q   <= phase_i;
    end
    if (!stall7 && s6_v_q) begin
      s7_val_q <= sat;
      s7_ph_q  <= s6_ph_q;
    end
  end

endmodule

[sv/beat_synced_lfo_waveform_unit.sv]
// Top level of the beat-synced LFO: configuration registers and the seven-stage pipeline.
//
// Each input transfer carries a song position in beats (unsigned Q16.16); the block returns one
// result transfer per input with the phase inside the selected period (Q0.16) and the LFO value
// (Q0.16, saturated at 65535). The block is stateless between items and fully pipelined: it
// takes one input transfer per clock cycle while the input is not stalled. The seven register
// stages are: period decode and modulo-three reciprocal product, division of the six-beat
// remainder by three, phase select, cosine table read, shape select, span multiply, and offset,
// inversion and saturation. The sine shape uses a 257-entry quarter-wave cosine table held as
// constant logic, with no interpolation. A stall on the output only backs up through stages that
// are full, so bubbles inside the pipeline are squeezed out and the input keeps accepting
// transfers while a finished result waits, until the stages behind it are full. The configuration
// port is always ready; registers must be written only while no transfer is in flight. Period
// select codes of nine and above give the 32-beat period, and a lower end above the upper end
// gives a zero span, so the output is the lower end (or its inverse).
module beat_synced_lfo_waveform_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bslfo_pkg::PosW-1:0]       beat_position_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bslfo_pkg::ValueW-1:0]     lfo_value_o,
  output logic [bslfo_pkg::PhaseW-1:0]     phase_o,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bslfo_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [bslfo_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bslfo_pkg::*;

  logic [PeriodSelW-1:0] period_select_q;
  waveform_e             waveform_q;
  logic [ValueW-1:0]     out_min_q;
  logic [ValueW-1:0]     out_max_q;
  logic                  invert_q;
  logic [ValueW-1:0]     span_q;
  logic [ValueW-1:0]     span_d;
  logic                  cfg_write;
  cfg_t                  cfg;

  // The configuration port never back-pressures.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_select_q <= PeriodSelW'(5);
      waveform_q      <= WaveSine;
      out_min_q       <= '0;
      out_max_q       <= {ValueW{1'b1}};
      invert_q        <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgPeriodSelect: period_select_q <= cfg_data_i[PeriodSelW-1:0];
        CfgWaveform:     waveform_q      <= waveform_e'(cfg_data_i[1:0]);
        CfgOutMin:       out_min_q       <= cfg_data_i[ValueW-1:0];
        CfgOutMax:       out_max_q       <= cfg_data_i[ValueW-1:0];
        CfgInvert:       invert_q        <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  // The span is registered from the bound registers, so it settles after them, long before any item needs it.
  assign span_d = (out_max_q > out_min_q) ? (out_max_q - out_min_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= {ValueW{1'b1}};
    end else begin
      span_q <= span_d;
    end
  end

  assign cfg.period_select = period_select_q;
  assign cfg.waveform      = waveform_q;
  assign cfg.out_min       = out_min_q;
  assign cfg.span          = span_q;
  assign cfg.invert        = invert_q;

  // Pipeline sections, linked by valid and stall.
  logic              ph_valid, ph_stall;
  logic [PhaseW-1:0] ph_phase;
  logic              sh_valid, sh_stall;
  logic [ShapeW-1:0] sh_shape;
  logic [PhaseW-1:0] sh_phase;

  bslfo_phase u_phase (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_i),
    .stall_o         (in_stall_o),
    .beat_position_i (beat_position_i),
    .cfg_i           (cfg),
    .valid_o         (ph_valid),
    .stall_i         (ph_stall),
    .phase_o         (ph_phase)
  );

  bslfo_shape u_shape (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph_valid),
    .stall_o (ph_stall),
    .phase_i (ph_phase),
    .cfg_i   (cfg),
    .valid_o (sh_valid),
    .stall_i (sh_stall),
    .shape_o (sh_shape),
    .phase_o (sh_phase)
  );

  bslfo_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (sh_valid),
    .stall_o     (sh_stall),
    .shape_i     (sh_shape),
    .phase_i     (sh_phase),
    .cfg_i       (cfg),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .lfo_value_o (lfo_value_o),
    .phase_o     (phase_o)
  );

  // With an empty output stage nothing upstream can be held.
  a_no_stall_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output stage is empty");

  // Back-pressure on the input only ever comes from the output side.
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without an output stall");

endmodule
